// ----- design/qau_pkg.sv -----
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, operation codes and saturation helper for the quaternion
// arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int QAU_WORD_BITS = 32;
  localparam int QAU_FRAC_BITS = 16;

  localparam int QAU_PROD_W = 2 * QAU_WORD_BITS;
  localparam int QAU_SUM_W  = QAU_PROD_W + 2;
  localparam int QAU_LIN_W  = QAU_WORD_BITS + 1;
  localparam int QAU_NPROD  = 16;

  localparam logic [2:0] FUNC_ADD  = 3'd0;
  localparam logic [2:0] FUNC_SUB  = 3'd1;
  localparam logic [2:0] FUNC_MUL  = 3'd2;
  localparam logic [2:0] FUNC_CONJ = 3'd3;
  localparam logic [2:0] FUNC_MAG  = 3'd4;

  // Operand selection for the product array; component order is s, x, y, z.
  // Products 0..3 are the diagonal terms, then three groups of four for the
  // x, y and z results (last term of each group is subtracted).
  localparam logic [1:0] PROD_A_IDX [QAU_NPROD] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd2, 2'd3, 2'd1,
    2'd0, 2'd3, 2'd1, 2'd2
  };
  localparam logic [1:0] PROD_B_IDX [QAU_NPROD] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd2, 2'd1
  };

  typedef struct packed {
    logic [2:0]                       func;
    logic signed [QAU_WORD_BITS-1:0]  first_scalar;
    logic signed [QAU_WORD_BITS-1:0]  first_x;
    logic signed [QAU_WORD_BITS-1:0]  first_y;
    logic signed [QAU_WORD_BITS-1:0]  first_z;
    logic signed [QAU_WORD_BITS-1:0]  second_scalar;
    logic signed [QAU_WORD_BITS-1:0]  second_x;
    logic signed [QAU_WORD_BITS-1:0]  second_y;
    logic signed [QAU_WORD_BITS-1:0]  second_z;
  } qau_in_t;

  typedef struct packed {
    logic signed [QAU_WORD_BITS-1:0]  res_scalar;
    logic signed [QAU_WORD_BITS-1:0]  res_x;
    logic signed [QAU_WORD_BITS-1:0]  res_y;
    logic signed [QAU_WORD_BITS-1:0]  res_z;
    logic                             overflow;
  } qau_out_t;

  typedef struct packed {
    logic signed [QAU_WORD_BITS-1:0]  value;
    logic                             ovf;
  } qau_sat_t;

  function automatic qau_sat_t qau_sat(input logic signed [QAU_SUM_W-1:0] v);
    logic [QAU_SUM_W-QAU_WORD_BITS:0] hi;
    qau_sat_t                         r;
    hi = v[QAU_SUM_W-1:QAU_WORD_BITS-1];
    if ((&hi) || (~|hi)) begin
      r.value = v[QAU_WORD_BITS-1:0];
      r.ovf   = 1'b0;
    end else begin
      r.ovf   = 1'b1;
      r.value = v[QAU_SUM_W-1] ? {1'b1, {(QAU_WORD_BITS-1){1'b0}}}
                               : {1'b0, {(QAU_WORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [QAU_SUM_W-1:0] qau_ext_prod(
    input logic signed [QAU_PROD_W-1:0] p
  );
    return {{(QAU_SUM_W-QAU_PROD_W){p[QAU_PROD_W-1]}}, p};
  endfunction

  function automatic logic signed [QAU_SUM_W-1:0] qau_ext_lin(
    input logic signed [QAU_LIN_W-1:0] l
  );
    return {{(QAU_SUM_W-QAU_LIN_W){l[QAU_LIN_W-1]}}, l};
  endfunction

endpackage

// ----- design/qau_mul_array.sv -----
// ----------------------------------------------------------------------------
// qau_mul_array
// Sixteen registered signed word-by-word products of the two quaternions;
// for squared magnitude the diagonal products square the first operand.
// ----------------------------------------------------------------------------
module qau_mul_array
  import qau_pkg::*;
(
  input  logic                          clk,
  input  qau_in_t                       op,
  input  logic                          mag,
  output logic signed [QAU_PROD_W-1:0]  prod_r [QAU_NPROD]
);

  logic signed [QAU_WORD_BITS-1:0] first_q  [4];
  logic signed [QAU_WORD_BITS-1:0] second_q [4];
  logic signed [QAU_WORD_BITS-1:0] opa      [QAU_NPROD];
  logic signed [QAU_WORD_BITS-1:0] opb      [QAU_NPROD];
  logic signed [QAU_PROD_W-1:0]    prod_nxt [QAU_NPROD];

  always_comb begin
    first_q[0]  = op.first_scalar;
    first_q[1]  = op.first_x;
    first_q[2]  = op.first_y;
    first_q[3]  = op.first_z;
    second_q[0] = op.second_scalar;
    second_q[1] = op.second_x;
    second_q[2] = op.second_y;
    second_q[3] = op.second_z;
    for (int k = 0; k < QAU_NPROD; k++) begin
      opa[k] = first_q[PROD_A_IDX[k]];
      opb[k] = (mag && (k < 4)) ? first_q[PROD_B_IDX[k]] : second_q[PROD_B_IDX[k]];
      prod_nxt[k] = opa[k] * opb[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QAU_NPROD; k++) begin
      prod_r[k] <= prod_nxt[k];
    end
  end

endmodule

// ----- design/quaternion_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Add, subtract, Hamilton product, conjugate and squared magnitude of
// signed fixed-point quaternions, truncated and saturated to the word.
//
//   channel  | ports                        | beat marked by
//   ---------+------------------------------+---------------------------
//   input    | start, busy, in_data         | start high, busy low
//   result   | out_valid, out_data          | out_valid high, one cycle
//
// Three-stage pipeline: input register, product register, result register.
// One beat is taken every cycle; its result strobes after passing the input, product and result registers.
// busy is tied low: the multiplier array and adders are fully pipelined.
// Reset clears only the valid bits of the pipeline.
// The receiver cannot stall; every result is presented exactly once.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit
  import qau_pkg::*;
#(
  parameter int FRAC_BITS = QAU_FRAC_BITS
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  qau_in_t  in_data,
  output logic     out_valid,
  output qau_out_t out_data
);

  qau_in_t                       in_r;
  logic                          v1_r;
  logic                          v2_r;
  logic [2:0]                    func2_r;
  logic signed [QAU_LIN_W-1:0]   lin_r   [4];
  logic signed [QAU_LIN_W-1:0]   lin_nxt [4];
  logic signed [QAU_WORD_BITS-1:0] first_q  [4];
  logic signed [QAU_WORD_BITS-1:0] second_q [4];
  logic signed [QAU_PROD_W-1:0]  prod_r  [QAU_NPROD];
  logic signed [QAU_SUM_W-1:0]   ext     [QAU_NPROD];
  logic signed [QAU_SUM_W-1:0]   sum     [4];
  logic signed [QAU_SUM_W-1:0]   shifted [4];
  qau_sat_t                      sat     [4];
  logic                          out_valid_r;
  qau_out_t                      out_data_r;
  qau_out_t                      out_data_nxt;

  assign busy = 1'b0;

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_r <= in_data;
    end
  end

  // stage 2: products and linear ops
  qau_mul_array u_mul (
    .clk    (clk),
    .op     (in_r),
    .mag    (in_r.func == FUNC_MAG),
    .prod_r (prod_r)
  );

  always_comb begin
    first_q[0]  = in_r.first_scalar;
    first_q[1]  = in_r.first_x;
    first_q[2]  = in_r.first_y;
    first_q[3]  = in_r.first_z;
    second_q[0] = in_r.second_scalar;
    second_q[1] = in_r.second_x;
    second_q[2] = in_r.second_y;
    second_q[3] = in_r.second_z;
    for (int c = 0; c < 4; c++) begin
      unique case (in_r.func)
        FUNC_ADD: lin_nxt[c] = {first_q[c][QAU_WORD_BITS-1], first_q[c]}
                             + {second_q[c][QAU_WORD_BITS-1], second_q[c]};
        FUNC_SUB: lin_nxt[c] = {first_q[c][QAU_WORD_BITS-1], first_q[c]}
                             - {second_q[c][QAU_WORD_BITS-1], second_q[c]};
        FUNC_CONJ: begin
          if (c == 0) begin
            lin_nxt[c] = {first_q[c][QAU_WORD_BITS-1], first_q[c]};
          end else begin
            lin_nxt[c] = -{first_q[c][QAU_WORD_BITS-1], first_q[c]};
          end
        end
        default: lin_nxt[c] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    func2_r <= in_r.func;
    for (int c = 0; c < 4; c++) begin
      lin_r[c] <= lin_nxt[c];
    end
  end

  // stage 3: sums, truncating shift, saturation
  always_comb begin
    for (int k = 0; k < QAU_NPROD; k++) begin
      ext[k] = qau_ext_prod(prod_r[k]);
    end
    if (func2_r == FUNC_MAG) begin
      sum[0] = ext[0] + ext[1] + ext[2] + ext[3];
    end else begin
      sum[0] = ext[0] - ext[1] - ext[2] - ext[3];
    end
    for (int c = 1; c < 4; c++) begin
      sum[c] = ext[4*c] + ext[4*c+1] + ext[4*c+2] - ext[4*c+3];
    end
    for (int c = 0; c < 4; c++) begin
      shifted[c] = sum[c] >>> FRAC_BITS;
    end

    out_data_nxt = '0;
    unique case (func2_r)
      FUNC_ADD, FUNC_SUB, FUNC_CONJ: begin
        for (int c = 0; c < 4; c++) begin
          sat[c] = qau_sat(qau_ext_lin(lin_r[c]));
        end
      end
      FUNC_MUL: begin
        for (int c = 0; c < 4; c++) begin
          sat[c] = qau_sat(shifted[c]);
        end
      end
      FUNC_MAG: begin
        sat[0] = qau_sat(shifted[0]);
        for (int c = 1; c < 4; c++) begin
          sat[c] = '0;
        end
      end
      default: begin
        for (int c = 0; c < 4; c++) begin
          sat[c] = '0;
        end
      end
    endcase
    out_data_nxt.res_scalar = sat[0].value;
    out_data_nxt.res_x      = sat[1].value;
    out_data_nxt.res_y      = sat[2].value;
    out_data_nxt.res_z      = sat[3].value;
    out_data_nxt.overflow   = sat[0].ovf | sat[1].ovf | sat[2].ovf | sat[3].ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
